@@ hw/rtl/ncbm_pkg.sv @@
// Shared types, codes and constants for the nearest-centroid box matcher.
`timescale 1ns / 1ps

package ncbm_pkg;

    // Geometry of the fields
    localparam int COORD_BITS     = 14;
    localparam int CENTRE_W       = COORD_BITS + 1;
    localparam int SQ_W           = 2 * CENTRE_W;
    localparam int DIST_W         = 31;
    localparam int BOUND_W        = 34;
    localparam int LIMIT_W        = 16;
    localparam int INDEX_W        = 6;
    localparam int OPCODE_W       = 2;
    localparam int STATUS_W       = 2;

    localparam int               MAX_BOXES_DEF = 64;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'd1000;
    localparam logic [BOUND_W-1:0] BOUND_RESET = 34'd4000000;

    // Opcodes
    localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_LOAD  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_QUERY = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MATCH    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_MATCH = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // take the input item this cycle
        logic issue;    // read the table at the scan address and advance
        logic finish;   // move the finished result into the output register
    } ncbm_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_req;  // presented item is a query and the table holds entries
        logic scan_last; // current scan address is the last filled entry
        logic busy;      // distance pipeline still holds entries
        logic out_free;  // output register can take a result this cycle
    } ncbm_sts_t;

endpackage

@@ hw/rtl/ncbm_ctrl.sv @@
// Controller state machine: accept, table scan, pipeline drain, result hand-off.
`timescale 1ns / 1ps

module ncbm_ctrl
    import ncbm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  ncbm_sts_t sts,
    output ncbm_cmd_t cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_FIN   = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sts.scan_req ? S_SCAN : S_FIN;
                end
            end
            S_SCAN:
            begin
                if (sts.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!sts.busy)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign cmd.accept = in_valid && (state_reg == S_IDLE);
    assign cmd.issue  = (state_reg == S_SCAN);
    assign cmd.finish = (state_reg == S_FIN) && sts.out_free;

endmodule

@@ hw/rtl/ncbm_dp.sv @@
// Datapath: centre table, distance pipeline, running minimum and output register.
`timescale 1ns / 1ps

module ncbm_dp
    import ncbm_pkg::*;
#(
    parameter int MAX_BOXES = MAX_BOXES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ncbm_cmd_t             cmd,
    output ncbm_sts_t             sts,
    input  logic [BOUND_W-1:0]    bound,
    input  logic [OPCODE_W-1:0]   opcode,
    input  logic [COORD_BITS-1:0] x_min,
    input  logic [COORD_BITS-1:0] y_min,
    input  logic [COORD_BITS-1:0] x_max,
    input  logic [COORD_BITS-1:0] y_max,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [STATUS_W-1:0]   status,
    output logic [INDEX_W-1:0]    match_index,
    output logic [DIST_W-1:0]     best_distance_sq
);

    localparam int ADDR_W = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
    localparam int CNT_W  = $clog2(MAX_BOXES + 1);

    // Centre table
    logic [CENTRE_W-1:0] mem_x [MAX_BOXES];
    logic [CENTRE_W-1:0] mem_y [MAX_BOXES];

    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    addr_reg;
    logic [OPCODE_W-1:0] op_reg;
    logic                full_reg;
    logic [CENTRE_W-1:0] cx_reg;
    logic [CENTRE_W-1:0] cy_reg;

    // Distance pipeline
    logic                v1_reg, v2_reg, v3_reg;
    logic [ADDR_W-1:0]   i1_reg, i2_reg, i3_reg;
    logic [CENTRE_W-1:0] rd_x_reg, rd_y_reg;
    logic [CENTRE_W-1:0] dx_reg, dy_reg;
    logic [SQ_W-1:0]     sqx_reg, sqy_reg;

    // Running minimum
    logic                found_reg;
    logic [DIST_W-1:0]   best_reg;
    logic [ADDR_W-1:0]   best_idx_reg;

    // Output register
    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [INDEX_W-1:0]  index_reg;
    logic [DIST_W-1:0]   dist_reg;

    logic [CENTRE_W-1:0] cx_in, cy_in;
    logic                has_room;
    logic [DIST_W-1:0]   d2;
    logic                in_limit;
    logic [31:0]         idx_wide;
    logic [STATUS_W-1:0] status_next;
    logic [INDEX_W-1:0]  index_next;
    logic [DIST_W-1:0]   dist_next;

    assign cx_in    = {1'b0, x_min} + {1'b0, x_max};
    assign cy_in    = {1'b0, y_min} + {1'b0, y_max};
    assign has_room = (count_reg < CNT_W'(MAX_BOXES));
    assign d2       = DIST_W'(sqx_reg) + DIST_W'(sqy_reg);
    assign in_limit = {{(BOUND_W-DIST_W){1'b0}}, best_reg} < bound;
    assign idx_wide = 32'(best_idx_reg);

    assign sts.scan_req  = (opcode == OP_QUERY) && (count_reg != '0);
    assign sts.scan_last = ((addr_reg + CNT_W'(1)) == count_reg);
    assign sts.busy      = v1_reg || v2_reg || v3_reg;
    assign sts.out_free  = !out_valid_reg || !out_stall;

    // Table writes and reads
    always_ff @(posedge clk)
    begin
        if (cmd.accept && (opcode == OP_LOAD) && has_room)
        begin
            mem_x[count_reg[ADDR_W-1:0]] <= cx_in;
            mem_y[count_reg[ADDR_W-1:0]] <= cy_in;
        end
        if (cmd.issue)
        begin
            rd_x_reg <= mem_x[addr_reg[ADDR_W-1:0]];
            rd_y_reg <= mem_y[addr_reg[ADDR_W-1:0]];
        end
    end

    // Item capture and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.accept)
        begin
            if (opcode == OP_CLEAR)
            begin
                count_reg <= '0;
            end
            else if ((opcode == OP_LOAD) && has_room)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg   <= opcode;
            full_reg <= !has_room;
            cx_reg   <= cx_in;
            cy_reg   <= cy_in;
        end
    end

    // Scan address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg <= '0;
        end
        else if (cmd.accept)
        begin
            addr_reg <= '0;
        end
        else if (cmd.issue)
        begin
            addr_reg <= addr_reg + CNT_W'(1);
        end
    end

    // Pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Pipeline payload: absolute differences, then squares
    always_ff @(posedge clk)
    begin
        i1_reg  <= addr_reg[ADDR_W-1:0];
        i2_reg  <= i1_reg;
        i3_reg  <= i2_reg;
        dx_reg  <= (cx_reg >= rd_x_reg) ? (cx_reg - rd_x_reg) : (rd_x_reg - cx_reg);
        dy_reg  <= (cy_reg >= rd_y_reg) ? (cy_reg - rd_y_reg) : (rd_y_reg - cy_reg);
        sqx_reg <= dx_reg * dx_reg;
        sqy_reg <= dy_reg * dy_reg;
    end

    // Running minimum; strict compare keeps the lowest index on ties
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            found_reg <= 1'b0;
        end
        else if (v3_reg)
        begin
            found_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v3_reg && (!found_reg || (d2 < best_reg)))
        begin
            best_reg     <= d2;
            best_idx_reg <= i3_reg;
        end
    end

    // Result of the finished item
    always_comb
    begin
        status_next = ST_DONE;
        index_next  = '0;
        dist_next   = '0;
        unique case (op_reg)
            OP_CLEAR:
            begin
                status_next = ST_DONE;
            end
            OP_LOAD:
            begin
                status_next = full_reg ? ST_FULL : ST_DONE;
            end
            OP_QUERY:
            begin
                if (found_reg && in_limit)
                begin
                    status_next = ST_MATCH;
                    index_next  = idx_wide[INDEX_W-1:0];
                    dist_next   = best_reg;
                end
                else
                begin
                    status_next = ST_NO_MATCH;
                end
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            status_reg <= status_next;
            index_reg  <= index_next;
            dist_reg   <= dist_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign match_index      = index_reg;
    assign best_distance_sq = dist_reg;

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_BOXES))
        else $error("fill count exceeds table depth");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> (addr_reg < count_reg))
        else $error("scan reads beyond filled entries");

    a_match_within: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == ST_MATCH))
            |-> ({{(BOUND_W-DIST_W){1'b0}}, dist_reg} < bound))
        else $error("match reported outside distance limit");

    a_no_finish_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> !(v1_reg || v2_reg || v3_reg))
        else $error("result taken while distance pipeline busy");

endmodule

@@ hw/rtl/nearest_centroid_box_matcher_core.sv @@
// Top level of the nearest-centroid box matcher: limit register, controller, datapath.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid / in_stall) carries one item: opcode and four box edges.
//   opcode 0 clears the table, 1 loads a previous-frame box, 2 queries a current-frame
//   box against every stored centre. Each item yields exactly one result item on the
//   output channel (out_valid / out_stall): status, match_index, best_distance_sq.
//   Clear and load go straight from acceptance to the result hand-off; a query scans
//   the N filled entries one per cycle through a four-stage distance pipeline (table
//   read, difference, square, minimum), lets the pipeline drain and then hands off
//   its result; with an empty table it skips the scan. One item is worked on at a
//   time through the table read port and the single distance pipeline, so the next
//   item is taken only once the last result has moved into the output register.
//   The output register holds a finished result while the receiver stalls; the next
//   item is accepted meanwhile and its result waits until that register frees.
//   distance_limit must be written through cfg_wr_en / cfg_wr_data while the block
//   is idle (the block does not enforce it); the squared bound follows in the next cycle.
//   Reset empties the table (fill count zero), sets distance_limit to 1000 and drops
//   any item in flight; the table contents are left undefined.
module nearest_centroid_box_matcher_core
    import ncbm_pkg::*;
#(
    parameter int MAX_BOXES = MAX_BOXES_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [OPCODE_W-1:0]   opcode,
    input  logic [COORD_BITS-1:0] x_min,
    input  logic [COORD_BITS-1:0] y_min,
    input  logic [COORD_BITS-1:0] x_max,
    input  logic [COORD_BITS-1:0] y_max,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [STATUS_W-1:0]   status,
    output logic [INDEX_W-1:0]    match_index,
    output logic [DIST_W-1:0]     best_distance_sq,
    input  logic                  cfg_wr_en,
    input  logic [LIMIT_W-1:0]    cfg_wr_data
);

    ncbm_cmd_t          cmd;
    ncbm_sts_t          sts;
    logic [LIMIT_W-1:0] limit_reg;
    logic [BOUND_W-1:0] bound_reg;
    logic [2*LIMIT_W-1:0] limit_sq;

    // Hold the distance limit; rewrite on a config write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            limit_reg <= cfg_wr_data;
        end
    end

    // Compare squared doubled-centre distances against 4 * limit^2.
    assign limit_sq = limit_reg * limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_reg <= BOUND_RESET;
        end
        else
        begin
            bound_reg <= {limit_sq, 2'b00};
        end
    end

    ncbm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    ncbm_dp #(
        .MAX_BOXES (MAX_BOXES)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .bound            (bound_reg),
        .opcode           (opcode),
        .x_min            (x_min),
        .y_min            (y_min),
        .x_max            (x_max),
        .y_max            (y_max),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .match_index      (match_index),
        .best_distance_sq (best_distance_sq)
    );

endmodule

@@ tb/tb_nearest_centroid_box_matcher_core.sv @@
// Testbench for the nearest-centroid box matcher: directed table, random scenes, predictor check.
`timescale 1ns / 1ps

module tb_nearest_centroid_box_matcher_core;
    import ncbm_pkg::*;

    // Opcode 3 has no meaning: the block gives status done and changes nothing
    localparam logic [OPCODE_W-1:0] OP_RESERVED = 2'd3;
    localparam int COORD_MAX      = (1 << COORD_BITS) - 1;
    localparam int ITEM_GOAL      = 1900;
    localparam int PHASES         = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 80;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  index;
        logic [DIST_W-1:0]   dist_sq;
    } match_res_t;

    typedef struct {
        int x0;
        int y0;
        int x1;
        int y1;
    } box_t;

    typedef struct {
        logic [OPCODE_W-1:0] op;
        box_t                box;
        bit                  pinned;
        match_res_t          res;
    } box_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [OPCODE_W-1:0]   opcode = OP_CLEAR;
    logic [COORD_BITS-1:0] x_min = '0;
    logic [COORD_BITS-1:0] y_min = '0;
    logic [COORD_BITS-1:0] x_max = '0;
    logic [COORD_BITS-1:0] y_max = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [STATUS_W-1:0]   status;
    logic [INDEX_W-1:0]    match_index;
    logic [DIST_W-1:0]     best_distance_sq;
    logic                  cfg_wr_en = 1'b0;
    logic [LIMIT_W-1:0]    cfg_wr_data = '0;

    // Expected result pinned to the item being driven (directed rows only)
    bit                    drv_pinned = 1'b0;
    match_res_t            drv_pinned_res = '0;

    // Predictor state: doubled centres, fill count, distance limit
    logic [CENTRE_W-1:0]   prev_cx [MAX_BOXES_DEF];
    logic [CENTRE_W-1:0]   prev_cy [MAX_BOXES_DEF];
    int                    prev_count = 0;
    logic [LIMIT_W-1:0]    dist_limit = LIMIT_RESET;

    match_res_t            pending_matches [$];
    box_t                  loaded_boxes [$];
    box_row_t              directed_rows [$];
    int                    mismatch_count = 0;
    int                    items_sent = 0;
    int                    sender_idle_pct = 0;
    int                    stall_pct = 0;

    always #6 clk = ~clk;

    nearest_centroid_box_matcher_core u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .opcode           (opcode),
        .x_min            (x_min),
        .y_min            (y_min),
        .x_max            (x_max),
        .y_max            (y_max),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .status           (status),
        .match_index      (match_index),
        .best_distance_sq (best_distance_sq),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data)
    );

    // Work out the result of one item and advance the predictor state
    function automatic match_res_t predict_match(input logic [OPCODE_W-1:0] op,
                                                 input logic [COORD_BITS-1:0] x0,
                                                 input logic [COORD_BITS-1:0] y0,
                                                 input logic [COORD_BITS-1:0] x1,
                                                 input logic [COORD_BITS-1:0] y1);
        logic [CENTRE_W-1:0] cx;
        logic [CENTRE_W-1:0] cy;
        longint              dx;
        longint              dy;
        longint              d2;
        longint              best;
        longint              lim;
        longint              bound;
        int                  best_j;
        bit                  found;
        match_res_t          r;
        cx     = {1'b0, x0} + {1'b0, x1};
        cy     = {1'b0, y0} + {1'b0, y1};
        r      = '0;
        best   = 0;
        best_j = 0;
        found  = 1'b0;
        case (op)
            OP_CLEAR: prev_count = 0;
            OP_LOAD:
            begin
                if (prev_count < MAX_BOXES_DEF)
                begin
                    prev_cx[prev_count] = cx;
                    prev_cy[prev_count] = cy;
                    prev_count++;
                end
                else
                begin
                    r.status = ST_FULL;
                end
            end
            OP_QUERY:
            begin
                lim   = longint'(dist_limit);
                bound = 4 * lim * lim;
                for (int j = 0; j < prev_count; j++)
                begin
                    dx = longint'(cx) - longint'(prev_cx[j]);
                    dy = longint'(cy) - longint'(prev_cy[j]);
                    d2 = dx * dx + dy * dy;
                    // strict compare keeps the lowest index on ties
                    if (!found || d2 < best)
                    begin
                        best   = d2;
                        best_j = j;
                        found  = 1'b1;
                    end
                end
                if (found && best < bound)
                begin
                    r.status  = ST_MATCH;
                    r.index   = best_j[INDEX_W-1:0];
                    r.dist_sq = best[DIST_W-1:0];
                end
                else
                begin
                    r.status = ST_NO_MATCH;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Compare accepted results, predict accepted items, follow register writes
    always @(posedge clk)
    begin : result_checker
        match_res_t want;
        match_res_t got;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_matches.size() == 0)
                begin
                    report_mismatch("result with nothing pending, status",
                                    longint'(status), 0);
                end
                else
                begin
                    want = pending_matches.pop_front();
                    if (status !== want.status)
                        report_mismatch("status", longint'(status), longint'(want.status));
                    if (match_index !== want.index)
                        report_mismatch("match_index", longint'(match_index),
                                        longint'(want.index));
                    if (best_distance_sq !== want.dist_sq)
                        report_mismatch("best_distance_sq", longint'(best_distance_sq),
                                        longint'(want.dist_sq));
                end
            end
            if (in_valid && !in_stall)
            begin
                got = predict_match(opcode, x_min, y_min, x_max, y_max);
                pending_matches.insert(pending_matches.size(),
                                       drv_pinned ? drv_pinned_res : got);
            end
            if (cfg_wr_en)
                dist_limit = cfg_wr_data;
        end
    end

    // Receiver stalls at random according to the current idling phase
    always @(posedge clk)
    begin
        out_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    // Watchdog: end the run when nothing moves for too long
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    function automatic box_t rand_box(input bit narrow);
        box_t b;
        int   hi;
        hi   = narrow ? 15 : COORD_MAX;
        b.x0 = $urandom_range(hi);
        b.y0 = $urandom_range(hi);
        b.x1 = $urandom_range(hi);
        b.y1 = $urandom_range(hi);
        return b;
    endfunction

    function automatic int jitter(input int v, input int r);
        int n;
        n = v + $urandom_range(2 * r) - r;
        if (n < 0)
            n = 0;
        if (n > COORD_MAX)
            n = COORD_MAX;
        return n;
    endfunction

    function automatic box_row_t make_row(input logic [OPCODE_W-1:0] op,
                                          input int x0, input int y0,
                                          input int x1, input int y1,
                                          input bit pin, input logic [STATUS_W-1:0] st,
                                          input int idx, input longint dist_val);
        box_row_t row;
        row.op          = op;
        row.box         = '{x0, y0, x1, y1};
        row.pinned      = pin;
        row.res.status  = st;
        row.res.index   = idx[INDEX_W-1:0];
        row.res.dist_sq = dist_val[DIST_W-1:0];
        return row;
    endfunction

    // Append one row to the directed table
    task automatic add_row(input box_row_t row);
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // Pick the idling phase from the running item count: none, sender, receiver, both
    task automatic pick_idling;
        case ((items_sent / 50) % 4)
            0:
            begin
                sender_idle_pct = 0;
                stall_pct       = 0;
            end
            1:
            begin
                sender_idle_pct = 78;
                stall_pct       = 0;
            end
            2:
            begin
                sender_idle_pct = 0;
                stall_pct       = 78;
            end
            default:
            begin
                sender_idle_pct = 27;
                stall_pct       = 27;
            end
        endcase
    endtask

    // Drive one item and hold it until the block takes it
    task automatic send_box(input logic [OPCODE_W-1:0] op, input box_t b,
                            input bit pin = 1'b0, input match_res_t pin_res = '0);
        pick_idling();
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        opcode         <= op;
        x_min          <= b.x0[COORD_BITS-1:0];
        y_min          <= b.y0[COORD_BITS-1:0];
        x_max          <= b.x1[COORD_BITS-1:0];
        y_max          <= b.y1[COORD_BITS-1:0];
        drv_pinned     <= pin;
        drv_pinned_res <= pin_res;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        if (op != OP_RESERVED)
            items_sent++;
        if (op == OP_CLEAR)
            loaded_boxes.delete();
        if (op == OP_LOAD)
            loaded_boxes.insert(loaded_boxes.size(), b);
    endtask

    // Hold the sender until every pending result is back, then let the pipe settle;
    // first wait for a clock edge so the item taken at the current edge is already queued
    task automatic drain(input int settle);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_matches.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        drain(8);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        // the squared bound is registered behind the limit register
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [LIMIT_W-1:0] limit_for_phase(input int phase);
        case (phase)
            0: return LIMIT_W'($urandom_range(3000, 200));
            1: return '0;
            2: return '1;
            3: return 16'd1;
            4: return LIMIT_W'($urandom_range(65535));
            5: return LIMIT_W'($urandom_range(2000, 20));
            6: return 16'd5;
            default: return LIMIT_RESET;
        endcase
    endfunction

    // One scene: mostly clear, a run of loads and queries near them; sometimes noise
    task automatic run_scene(input int scene);
        int   n_loads;
        int   n_queries;
        int   sel;
        int   r;
        bit   narrow;
        box_t base;
        box_t b;
        if (scene != 0 && $urandom_range(7) == 0)
        begin
            repeat ($urandom_range(4, 1))
                send_box(2'($urandom_range(3)), rand_box(1'($urandom_range(1))));
            return;
        end
        narrow = ($urandom_range(3) == 0);
        if ($urandom_range(4) != 0)
            send_box(OP_CLEAR, rand_box(1'b0));
        // now and then fill the table and push a few loads past it
        if (scene == 0 || $urandom_range(14) == 0)
            n_loads = MAX_BOXES_DEF + $urandom_range(3, 1);
        else
            n_loads = $urandom_range(12, 1);
        repeat (n_loads)
            send_box(OP_LOAD, rand_box(narrow));
        n_queries = $urandom_range(10, 1);
        repeat (n_queries)
        begin
            if (loaded_boxes.size() > 0 && $urandom_range(4) < 3)
            begin
                base = loaded_boxes[$urandom_range(loaded_boxes.size() - 1)];
                sel  = $urandom_range(2);
                r    = (sel == 0) ? 0 : (sel == 1) ? 3 :
                       (dist_limit > 3000 ? 3000 : int'(dist_limit));
                b.x0 = jitter(base.x0, r);
                b.y0 = jitter(base.y0, r);
                b.x1 = jitter(base.x1, r);
                b.y1 = jitter(base.y1, r);
            end
            else
            begin
                b = rand_box(narrow);
            end
            send_box(OP_QUERY, b);
        end
        if (scene % 17 == 5)
            drain(0);
    endtask

    initial
    begin
        int scene;
        int target;
        scene = 0;

        // Directed rows, run under the reset limit of 1000
        add_row(make_row(OP_QUERY, 5, 5, 9, 9, 1, ST_NO_MATCH, 0, 0));
        add_row(make_row(OP_RESERVED, COORD_MAX, COORD_MAX, COORD_MAX,
                         COORD_MAX, 1, ST_DONE, 0, 0));
        add_row(make_row(OP_LOAD, 0, 0, 0, 0, 1, ST_DONE, 0, 0));
        add_row(make_row(OP_LOAD, COORD_MAX, COORD_MAX, COORD_MAX,
                         COORD_MAX, 1, ST_DONE, 0, 0));
        // inverted box, loaded twice to set up a tie
        add_row(make_row(OP_LOAD, 300, 400, 100, 200, 1, ST_DONE, 0, 0));
        add_row(make_row(OP_LOAD, 300, 400, 100, 200, 1, ST_DONE, 0, 0));
        add_row(make_row(OP_RESERVED, 0, 0, 0, 0, 1, ST_DONE, 0, 0));
        add_row(make_row(OP_QUERY, 100, 200, 300, 400, 1, ST_MATCH, 2, 0));
        add_row(make_row(OP_QUERY, 0, 0, 0, 0, 1, ST_MATCH, 0, 0));
        add_row(make_row(OP_QUERY, COORD_MAX, COORD_MAX, COORD_MAX,
                         COORD_MAX, 1, ST_MATCH, 1, 0));
        add_row(make_row(OP_QUERY, 0, 0, 1, 0, 1, ST_MATCH, 0, 1));
        add_row(make_row(OP_QUERY, 8191, 8191, 8192, 8192, 0, ST_DONE, 0, 0));
        add_row(make_row(OP_CLEAR, 1234, 4321, 16000, 77, 1, ST_DONE, 0, 0));
        add_row(make_row(OP_QUERY, 0, 0, 0, 0, 1, ST_NO_MATCH, 0, 0));
        add_row(make_row(OP_LOAD, 0, 0, 0, 0, 1, ST_DONE, 0, 0));
        // exactly at the limit is rejected, one half pixel inside is taken
        add_row(make_row(OP_QUERY, 1000, 0, 1000, 0, 1, ST_NO_MATCH, 0, 0));
        add_row(make_row(OP_QUERY, 999, 0, 1000, 0, 1, ST_MATCH, 0, 3996001));
        add_row(make_row(OP_QUERY, COORD_MAX, COORD_MAX, COORD_MAX,
                         COORD_MAX, 1, ST_NO_MATCH, 0, 0));
        add_row(make_row(OP_LOAD, COORD_MAX, 0, COORD_MAX, 0, 1, ST_DONE, 0, 0));
        add_row(make_row(OP_QUERY, 8000, 3, 9000, 7, 0, ST_DONE, 0, 0));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_box(directed_rows[i].op, directed_rows[i].box,
                     directed_rows[i].pinned, directed_rows[i].res);

        // Random scenes, one limit setting per phase
        for (int phase = 0; phase < PHASES; phase++)
        begin
            write_limit(limit_for_phase(phase));
            target = (phase == PHASES - 1) ? ITEM_GOAL
                                           : items_sent + (ITEM_GOAL - items_sent) /
                                             (PHASES - phase);
            while (items_sent < target)
            begin
                run_scene(scene);
                scene++;
            end
        end

        drain(SETTLE_CYCLES);
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
hw/rtl/ncbm_pkg.sv
hw/rtl/ncbm_ctrl.sv
hw/rtl/ncbm_dp.sv
hw/rtl/nearest_centroid_box_matcher_core.sv
tb/tb_nearest_centroid_box_matcher_core.sv
